@@ hdl/snd_pkg.sv @@
// shared types, constants and lookup functions for the music string note decoder
`default_nettype none
package snd_pkg;

  localparam int DIV_W = 24;
  localparam int DSR_W = 22;
  localparam int CNT_W = $clog2(DIV_W);
  localparam int PROD_W = 42;

  localparam logic [15:0] TEMPO_RESET = 16'd120;
  localparam logic [23:0] TICK_RATE_RESET = 24'd1193182;
  localparam logic [31:0] OCT_RESET = 32'h100;
  localparam logic [15:0] REST_FREQ = 16'h7d00;
  localparam logic [15:0] DUR_DEFAULT = 16'd4;
  localparam logic [21:0] TICK_MUL = 22'd60;
  localparam logic [15:0] DUR_MAX = 16'hffff;
  localparam logic [15:0] TONE_MAX = 16'hffff;

  localparam logic CFG_TEMPO = 1'b0;
  localparam logic CFG_TICK_RATE = 1'b1;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_GT = 8'h3e;
  localparam logic [7:0] CH_LT = 8'h3c;
  localparam logic [7:0] CH_PLUS = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7a;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef struct packed {
    logic              rest;
    logic [3:0]        semi;
    logic signed [2:0] shift;
    logic [31:0]       octave;
    logic              dotted;
    logic [15:0]       dur;
  } note_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_FREQ,
    ST_TONE_GO,
    ST_TONE_WAIT,
    ST_TICK_GO,
    ST_TICK_WAIT,
    ST_DONE
  } back_state_t;

  function automatic logic [3:0] step_of(input logic [2:0] idx);
    logic [3:0] s;
    case (idx)
      3'd0: s = 4'd0;
      3'd1: s = 4'd2;
      3'd2: s = 4'd3;
      3'd3: s = 4'd5;
      3'd4: s = 4'd7;
      3'd5: s = 4'd8;
      3'd6: s = 4'd10;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [9:0] freq_of(input logic [3:0] semi);
    logic [9:0] f;
    case (semi)
      4'd0: f = 10'd440;
      4'd1: f = 10'd466;
      4'd2: f = 10'd494;
      4'd3: f = 10'd523;
      4'd4: f = 10'd554;
      4'd5: f = 10'd587;
      4'd6: f = 10'd622;
      4'd7: f = 10'd659;
      4'd8: f = 10'd698;
      4'd9: f = 10'd740;
      4'd10: f = 10'd784;
      4'd11: f = 10'd831;
      default: f = 10'd440;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

@@ hdl/music_string_note_decoder.sv @@
// Music string note decoder: tune characters in, one note result per '/'.
// Input channel: char_code and last_of_tune move on a beat when char_valid is high and
// char_stall is low. The front end takes a new character on every beat; the last
// character of a tune only re-arms the octave reset, except that a '/' there still
// ends the note.
// Output channel: tone_divisor, is_rest, tick_increment and total_ticks move on a beat
// when note_valid is high and note_stall is low. The fields hold while stalled.
// Back end: the divisor division is skipped when the note frequency comes out zero.
// Otherwise the back end runs one shared 24-step restoring divider twice per note
// (divisor, then tick length); with a zero frequency it runs it once, for the tick
// length. It takes no new note until its finished result has gone into the output
// register. Finished notes wait in a QUEUE_DEPTH deep queue; char_stall rises only
// when that queue is full, and the back end starts the next note while a result
// waits in the output register.
// Configuration: cfg_write_en with cfg_index (0 tempo, 1 clock tick rate) and cfg_data
// write a register; write only while no note is in flight.
// Reset (rst, synchronous): tempo 120, clock tick rate 1193182, octave scale 256,
// running total 0, queue empty, no result pending.
`default_nettype none
module music_string_note_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_write_en,
  input  wire         cfg_index,
  input  wire  [23:0] cfg_data,
  input  wire         char_valid,
  output logic        char_stall,
  input  wire  [7:0]  char_code,
  input  wire         last_of_tune,
  output logic        note_valid,
  input  wire         note_stall,
  output logic [15:0] tone_divisor,
  output logic        is_rest,
  output logic [11:0] tick_increment,
  output logic [31:0] total_ticks
);

  logic [15:0]    tempo;
  logic [23:0]    clock_tick_rate;
  logic           push, pop, full, empty;
  snd_pkg::note_t front_rec, queue_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      tempo <= snd_pkg::TEMPO_RESET;
      clock_tick_rate <= snd_pkg::TICK_RATE_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        snd_pkg::CFG_TEMPO: tempo <= cfg_data[15:0];
        snd_pkg::CFG_TICK_RATE: clock_tick_rate <= cfg_data;
        default: tempo <= tempo;
      endcase
    end
  end

  snd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .last_of_tune (last_of_tune),
    .full         (full),
    .push         (push),
    .rec          (front_rec)
  );

  snd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_rec),
    .pop   (pop),
    .rdata (queue_rec),
    .full  (full),
    .empty (empty)
  );

  snd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .tempo           (tempo),
    .clock_tick_rate (clock_tick_rate),
    .empty           (empty),
    .rec             (queue_rec),
    .pop             (pop),
    .note_valid      (note_valid),
    .note_stall      (note_stall),
    .tone_divisor    (tone_divisor),
    .is_rest         (is_rest),
    .tick_increment  (tick_increment),
    .total_ticks     (total_ticks)
  );

endmodule
`default_nettype wire

@@ hdl/snd_front.sv @@
// front end: takes tune character beats, tracks note state and queues finished notes
`default_nettype none
module snd_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 char_valid,
  output logic                char_stall,
  input  wire  [7:0]          char_code,
  input  wire                 last_of_tune,
  input  wire                 full,
  output logic                push,
  output snd_pkg::note_t      rec
);

  logic [31:0] octave, octave_next;
  logic        at_start, at_start_next;
  logic [5:0]  sharp, sharp_next;
  logic        dotted, dotted_next;
  logic [3:0]  step, step_next;
  logic        rest, rest_next;
  logic [15:0] dur, dur_next;

  logic        accept;
  logic [7:0]  cf;
  logic [7:0]  letter_off;
  logic [7:0]  digit;
  logic [19:0] dur_x10;
  logic [31:0] oct_eff;
  logic signed [6:0] sum;
  logic signed [6:0] semi_s;
  logic signed [2:0] shift;

  assign char_stall = full;
  assign accept = char_valid && !full;
  assign oct_eff = at_start ? snd_pkg::OCT_RESET : octave;
  assign cf = (char_code inside {[snd_pkg::CH_LOW_A:snd_pkg::CH_LOW_Z]}) ?
              char_code - snd_pkg::CASE_GAP : char_code;
  assign letter_off = cf - snd_pkg::CH_A;
  assign digit = cf - snd_pkg::CH_0;
  assign dur_x10 = {dur, 3'b000} + {2'b00, dur, 1'b0} + {12'd0, digit};

  // split step plus sharps into an octave shift and a semitone
  assign sum = $signed({3'b000, step}) + $signed({sharp[5], sharp});
  always_comb begin
    if (sum < -7'sd24) begin
      shift = -3'sd3;
      semi_s = sum + 7'sd36;
    end else if (sum < -7'sd12) begin
      shift = -3'sd2;
      semi_s = sum + 7'sd24;
    end else if (sum < 7'sd0) begin
      shift = -3'sd1;
      semi_s = sum + 7'sd12;
    end else if (sum < 7'sd12) begin
      shift = 3'sd0;
      semi_s = sum;
    end else if (sum < 7'sd24) begin
      shift = 3'sd1;
      semi_s = sum - 7'sd12;
    end else if (sum < 7'sd36) begin
      shift = 3'sd2;
      semi_s = sum - 7'sd24;
    end else begin
      shift = 3'sd3;
      semi_s = sum - 7'sd36;
    end
  end

  always_comb begin
    rec.rest = rest;
    rec.semi = semi_s[3:0];
    rec.shift = shift;
    rec.octave = oct_eff;
    rec.dotted = dotted;
    rec.dur = dur;
  end

  always_comb begin
    octave_next = octave;
    at_start_next = at_start;
    sharp_next = sharp;
    dotted_next = dotted;
    step_next = step;
    rest_next = rest;
    dur_next = dur;
    push = 1'b0;
    if (accept) begin
      octave_next = oct_eff;
      at_start_next = 1'b0;
      if (last_of_tune) begin
        at_start_next = 1'b1;
      end else if (cf inside {[snd_pkg::CH_A:snd_pkg::CH_G]}) begin
        step_next = snd_pkg::step_of(letter_off[2:0]);
        rest_next = 1'b0;
      end else if (cf == snd_pkg::CH_R) begin
        rest_next = 1'b1;
      end else if (cf == snd_pkg::CH_GT) begin
        octave_next = {oct_eff[30:0], 1'b0};
      end else if (cf == snd_pkg::CH_LT) begin
        octave_next = {1'b0, oct_eff[31:1]};
      end else if (cf == snd_pkg::CH_PLUS) begin
        sharp_next = sharp + 6'd1;
      end else if (cf == snd_pkg::CH_MINUS) begin
        sharp_next = sharp - 6'd1;
      end else if (cf == snd_pkg::CH_DOT) begin
        dotted_next = 1'b1;
      end else if (cf inside {[snd_pkg::CH_0:snd_pkg::CH_9]}) begin
        dur_next = (dur_x10[19:16] != 4'd0) ? snd_pkg::DUR_MAX : dur_x10[15:0];
      end
      if (cf == snd_pkg::CH_SLASH) begin
        push = 1'b1;
        sharp_next = 6'd0;
        dotted_next = 1'b0;
        step_next = 4'd0;
        rest_next = 1'b1;
        dur_next = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octave <= snd_pkg::OCT_RESET;
      at_start <= 1'b1;
      sharp <= 6'd0;
      dotted <= 1'b0;
      step <= 4'd0;
      rest <= 1'b1;
      dur <= 16'd0;
    end else begin
      octave <= octave_next;
      at_start <= at_start_next;
      sharp <= sharp_next;
      dotted <= dotted_next;
      step <= step_next;
      rest <= rest_next;
      dur <= dur_next;
    end
  end

endmodule
`default_nettype wire

@@ hdl/snd_queue.sv @@
// short note queue between the front end and the back end
`default_nettype none
module snd_queue #(
  parameter int DEPTH = 2
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  snd_pkg::note_t      wdata,
  input  wire                 pop,
  output snd_pkg::note_t      rdata,
  output logic                full,
  output logic                empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  snd_pkg::note_t store [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push, do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == CW'(0));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

@@ hdl/snd_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module snd_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [snd_pkg::DIV_W-1:0]    dividend,
  input  wire  [snd_pkg::DSR_W-1:0]    divisor,
  output snd_pkg::div_stat_t           stat,
  output logic [snd_pkg::DIV_W-1:0]    quotient
);

  logic [snd_pkg::DSR_W-1:0] rem;
  logic [snd_pkg::DSR_W-1:0] dsr;
  logic [snd_pkg::DIV_W-1:0] quo;
  logic [snd_pkg::CNT_W-1:0] cnt;
  logic                      busy, done;
  logic [snd_pkg::DSR_W:0]   shifted, diff;
  logic                      take;

  assign shifted = {rem, quo[snd_pkg::DIV_W-1]};
  assign diff = shifted - {1'b0, dsr};
  assign take = !diff[snd_pkg::DSR_W];
  assign quotient = quo;
  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + snd_pkg::CNT_W'(1);
        if (cnt == snd_pkg::CNT_W'(snd_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= take ? diff[snd_pkg::DSR_W-1:0] : shifted[snd_pkg::DSR_W-1:0];
      quo <= {quo[snd_pkg::DIV_W-2:0], take};
    end
  end

endmodule
`default_nettype wire

@@ hdl/snd_back.sv @@
// back end: turns a queued note into divisor, tick increment and running total
`default_nettype none
module snd_back (
  input  wire                          clk,
  input  wire                          rst,
  input  wire  [15:0]                  tempo,
  input  wire  [23:0]                  clock_tick_rate,
  input  wire                          empty,
  input  snd_pkg::note_t               rec,
  output logic                         pop,
  output logic                         note_valid,
  input  wire                          note_stall,
  output logic [15:0]                  tone_divisor,
  output logic                         is_rest,
  output logic [11:0]                  tick_increment,
  output logic [31:0]                  total_ticks
);

  snd_pkg::back_state_t state, state_next;
  snd_pkg::note_t       note_r;
  snd_pkg::div_stat_t   div_stat;

  logic [snd_pkg::PROD_W-1:0] prod_r;
  logic [15:0]                freq_r, freq_sel, tone_r;
  logic [16:0]                inc_r;
  logic [3:0]                 lsb;
  logic [15:0]                dur_eff;
  logic [17:0]                tick_num;
  logic [21:0]                tick_den;
  logic                       div_start;
  logic [snd_pkg::DIV_W-1:0]  div_dividend, quotient;
  logic [snd_pkg::DSR_W-1:0]  div_divisor;
  logic                       slot_free;
  logic                       load_out;

  assign slot_free = !note_valid || !note_stall;
  assign load_out = (state == snd_pkg::ST_DONE) && slot_free;

  // frequency is the freq*octave product, bits lsb+15:lsb with lsb = 8 - shift
  assign lsb = 4'd8 - {{1{note_r.shift[2]}}, note_r.shift};
  assign freq_sel = prod_r[lsb +: 16];

  assign dur_eff = (note_r.dur == 16'd0) ? snd_pkg::DUR_DEFAULT : note_r.dur;
  assign tick_num = note_r.dotted ? ({2'b00, tempo} + {1'b0, tempo, 1'b0}) :
                    {1'b0, tempo, 1'b0};
  assign tick_den = 22'(dur_eff) * snd_pkg::TICK_MUL;

  assign div_dividend = (state == snd_pkg::ST_TICK_GO) ?
                        snd_pkg::DIV_W'(tick_num) : clock_tick_rate;
  assign div_divisor = (state == snd_pkg::ST_TICK_GO) ?
                       tick_den : snd_pkg::DSR_W'(freq_r);

  snd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= snd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    div_start = 1'b0;
    case (state)
      snd_pkg::ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          state_next = snd_pkg::ST_MUL;
        end
      end
      snd_pkg::ST_MUL: state_next = snd_pkg::ST_FREQ;
      snd_pkg::ST_FREQ: state_next = snd_pkg::ST_TONE_GO;
      snd_pkg::ST_TONE_GO: begin
        if (freq_r == 16'd0) begin
          state_next = snd_pkg::ST_TICK_GO;
        end else begin
          div_start = 1'b1;
          state_next = snd_pkg::ST_TONE_WAIT;
        end
      end
      snd_pkg::ST_TONE_WAIT: begin
        if (div_stat.done) begin
          state_next = snd_pkg::ST_TICK_GO;
        end
      end
      snd_pkg::ST_TICK_GO: begin
        div_start = 1'b1;
        state_next = snd_pkg::ST_TICK_WAIT;
      end
      snd_pkg::ST_TICK_WAIT: begin
        if (div_stat.done) begin
          state_next = snd_pkg::ST_DONE;
        end
      end
      snd_pkg::ST_DONE: begin
        if (slot_free) begin
          state_next = snd_pkg::ST_IDLE;
        end
      end
      default: state_next = snd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      note_r <= rec;
    end
    if (state == snd_pkg::ST_MUL) begin
      prod_r <= snd_pkg::PROD_W'(snd_pkg::freq_of(note_r.semi)) *
                snd_pkg::PROD_W'(note_r.octave);
    end
    if (state == snd_pkg::ST_FREQ) begin
      freq_r <= note_r.rest ? snd_pkg::REST_FREQ : freq_sel;
    end
    if (state == snd_pkg::ST_TONE_GO && freq_r == 16'd0) begin
      tone_r <= snd_pkg::TONE_MAX;
    end
    if (state == snd_pkg::ST_TONE_WAIT && div_stat.done) begin
      tone_r <= (quotient[23:16] != 8'd0) ? snd_pkg::TONE_MAX : quotient[15:0];
    end
    if (state == snd_pkg::ST_TICK_WAIT && div_stat.done) begin
      inc_r <= quotient[17:1];
    end
    if (load_out) begin
      tone_divisor <= tone_r;
      is_rest <= note_r.rest;
      tick_increment <= inc_r[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      note_valid <= 1'b0;
      total_ticks <= 32'd0;
    end else begin
      if (load_out) begin
        note_valid <= 1'b1;
        total_ticks <= total_ticks + 32'(inc_r);
      end else if (!note_stall) begin
        note_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == snd_pkg::ST_TONE_WAIT || state == snd_pkg::ST_TICK_WAIT))
    else $error("divider running outside a wait state");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == snd_pkg::ST_TONE_WAIT || state == snd_pkg::ST_TICK_WAIT))
    else $error("divider result with no one waiting");

  a_total_adds_inc: assert property (@(posedge clk) disable iff (rst)
    load_out |=> note_valid && total_ticks == $past(total_ticks) + 32'($past(inc_r)))
    else $error("running total not advanced by the note increment");

  a_total_holds: assert property (@(posedge clk) disable iff (rst)
    !load_out |=> $stable(total_ticks))
    else $error("running total changed without a note");
`endif

endmodule
`default_nettype wire
